// ===== rtl/blfb_pkg.sv =====
// shared types and codes of the line drawing framebuffer
package blfb_pkg;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_PIXEL = 2'd1,
		ACT_LINE  = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	localparam int COORD_W = 8;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 9;
	localparam int DATA_W  = 8;
	localparam int PAGE_ROWS = 8;

	// one point coming out of the line stepper
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pt_t;

endpackage

// ===== rtl/bresenham_line_framebuffer.sv =====
// top level: command decode, framebuffer read-modify-write and result register
//
// Commands come in on the s_ channel, one word per command; the command
// kind rides on s_tuser. Every command gives exactly one result word on the
// m_ channel.
// Steps per command, from acceptance to the result register:
//   clear      one zero write per byte of the store (1024 bytes by default)
//   set pixel  a line of a single point
//   draw line  one point per cycle (up to 256 points), each point a read of
//              the store and a write of the store in the cycle after the read
//   read byte  a read state, then a read-wait state for the registered data
// The store is a ram with one write and one registered read port; a write
// that lands on the byte read for the next point is forwarded.
// After reset the block sweeps the store to zero (one write per byte,
// 1024 bytes by default) with s_tready low and sends no result for it.
// A finished result sits in the output register; the next command is taken
// while it waits. If it is still not taken when the next command finishes,
// the engine holds and s_tready stays low until m_tready comes.
module bresenham_line_framebuffer
	import blfb_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24], byte_index[41:32]
	input  logic [47:0] s_tdata,
	// action[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[7:0], pixels_set[16:8]
	output logic [23:0] m_tdata
);

	localparam int PAGES       = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
	localparam int AW          = $clog2(STORE_BYTES);

	typedef enum logic [5:0] {
		ST_CLR  = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_LINE = 6'b000100,
		ST_RD   = 6'b001000,
		ST_RDW  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q;

	action_t            act;
	logic [COORD_W-1:0] in_sx, in_sy, in_ex, in_ey;
	logic [INDEX_W-1:0] in_idx;
	logic               accept;

	logic               clr_reply_q;
	logic [AW-1:0]      clr_addr_q;
	logic [INDEX_W-1:0] rd_idx_q;
	logic [DATA_W-1:0]  res_data_q;
	logic [COUNT_W-1:0] res_cnt_q;
	logic               out_valid_q;
	logic [23:0]        out_data_q;

	pt_t                pt;
	logic               line_start;

	logic               hit;
	logic [AW-1:0]      pt_addr;
	logic [DATA_W-1:0]  pt_mask;
	logic               act_s1, hit_s1, last_s1;
	logic [AW-1:0]      addr_s1;
	logic [DATA_W-1:0]  mask_s1;

	logic               wr_valid_q;
	logic [AW-1:0]      wr_addr_q;
	logic [DATA_W-1:0]  wr_data_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [DATA_W-1:0]  ram_wdata, ram_rdata;
	logic [DATA_W-1:0]  merged;
	logic               line_we;
	logic               out_free;

	assign act    = action_t'(s_tuser);
	assign in_sx  = s_tdata[7:0];
	assign in_sy  = s_tdata[15:8];
	assign in_ex  = s_tdata[23:16];
	assign in_ey  = s_tdata[31:24];
	assign in_idx = s_tdata[41:32];

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign line_start = accept && (act == ACT_PIXEL || act == ACT_LINE);
	assign out_free   = !out_valid_q || m_tready;

	// a pixel is a line whose end is its start
	blfb_line u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (line_start),
		.ax     (in_sx),
		.ay     (in_sy),
		.bx     ((act == ACT_PIXEL) ? in_sx : in_ex),
		.by     ((act == ACT_PIXEL) ? in_sy : in_ey),
		.pt     (pt)
	);

	// clip and address of the current point
	always_comb begin
		hit     = ({1'b0, pt.x} < 9'(SCREEN_WIDTH)) && ({1'b0, pt.y} < 9'(SCREEN_HEIGHT));
		pt_addr = AW'(pt.x) + AW'(pt.y >> 3) * AW'(SCREEN_WIDTH);
		pt_mask = DATA_W'(1) << pt.y[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= pt.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1  <= hit;
		last_s1 <= pt.last;
		addr_s1 <= pt_addr;
		mask_s1 <= pt_mask;
	end

	// forward the byte written in the previous cycle when the same byte comes back
	assign merged  = ((wr_valid_q && wr_addr_q == addr_s1) ? wr_data_q : ram_rdata) | mask_s1;
	assign line_we = act_s1 && hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else begin
			wr_valid_q <= line_we;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= addr_s1;
		wr_data_q <= merged;
	end

	always_comb begin
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = line_we;
			ram_waddr = addr_s1;
			ram_wdata = merged;
		end
		ram_raddr = (state_q == ST_RD) ? AW'(rd_idx_q) : pt_addr;
	end

	blfb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_reply_q <= 1'b0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					if (clr_addr_q == AW'(STORE_BYTES - 1)) begin
						clr_addr_q <= '0;
						state_q    <= clr_reply_q ? ST_FIN : ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (act) inside
							ACT_CLEAR: begin
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLR;
							end
							ACT_PIXEL, ACT_LINE: state_q <= ST_LINE;
							ACT_READ:            state_q <= ST_RD;
							default:             state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LINE: begin
					if (act_s1 && last_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_RD:  state_q <= ST_RDW;
				ST_RDW: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_idx_q   <= in_idx;
			res_data_q <= '0;
			res_cnt_q  <= '0;
		end
		if (state_q == ST_LINE && pt.valid && hit) begin
			res_cnt_q <= res_cnt_q + COUNT_W'(1);
		end
		if (state_q == ST_RDW) begin
			res_data_q <= (32'(rd_idx_q) < STORE_BYTES) ? ram_rdata : '0;
		end
		if (state_q == ST_FIN && out_free) begin
			out_data_q <= {7'd0, res_cnt_q, res_data_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/blfb_ram.sv =====
// generic simple dual port ram with registered read, read before write
module blfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/blfb_line.sv =====
// bresenham stepper, one point per cycle
module blfb_line
	import blfb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COORD_W-1:0] ax,
	input  logic [COORD_W-1:0] ay,
	input  logic [COORD_W-1:0] bx,
	input  logic [COORD_W-1:0] by,
	output pt_t                pt
);

	logic               busy_q;
	logic [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic [COORD_W-1:0] dx_q;
	logic signed [9:0]  dy_q;
	logic               stepx_neg_q, stepy_neg_q;
	logic signed [11:0] err_q;
	logic [7:0]         npts_q;

	logic [COORD_W-1:0] dx_new, dy_abs;
	logic               at_end, last;
	logic signed [12:0] twice;
	logic signed [11:0] err_nxt;
	logic               mv_x, mv_y;

	always_comb begin
		dx_new  = (bx > ax) ? bx - ax : ax - bx;
		dy_abs  = (by > ay) ? by - ay : ay - by;
		at_end  = (ax_q == bx_q) && (ay_q == by_q);
		last    = at_end || (npts_q == 8'hFF);
		twice   = 13'(err_q) <<< 1;
		mv_x    = twice > 13'(dy_q);
		mv_y    = twice < $signed({5'd0, dx_q});
		err_nxt = err_q;
		if (mv_x) begin
			err_nxt = err_nxt + 12'(dy_q);
		end
		if (mv_y) begin
			err_nxt = err_nxt + $signed({4'd0, dx_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ax_q        <= ax;
			ay_q        <= ay;
			bx_q        <= bx;
			by_q        <= by;
			dx_q        <= dx_new;
			dy_q        <= -$signed({2'd0, dy_abs});
			stepx_neg_q <= !(ax < bx);
			stepy_neg_q <= !(ay < by);
			err_q       <= $signed({4'd0, dx_new}) - $signed({4'd0, dy_abs});
			npts_q      <= '0;
		end else if (busy_q && !last) begin
			err_q  <= err_nxt;
			npts_q <= npts_q + 8'd1;
			if (mv_x) begin
				ax_q <= stepx_neg_q ? ax_q - 8'd1 : ax_q + 8'd1;
			end
			if (mv_y) begin
				ay_q <= stepy_neg_q ? ay_q - 8'd1 : ay_q + 8'd1;
			end
		end
	end

	assign pt.valid = busy_q;
	assign pt.last  = last;
	assign pt.x     = ax_q;
	assign pt.y     = ay_q;

endmodule

// ===== test/tb_top.sv =====
// testbench for the line drawing framebuffer: random and directed commands and a scoreboard
module tb_top;
	import blfb_pkg::*;

	localparam int SCREEN_W = 128;
	localparam int SCREEN_H = 64;
	localparam int STORE_BYTES = SCREEN_W * (SCREEN_H / PAGE_ROWS);
	localparam int LINE_POINT_MAX = 256;
	localparam int RANDOM_PER_PHASE = 550;
	localparam int SETTLE_CYCLES = 1100;
	localparam int unsigned TIMEOUT_UNITS = 16_000_000;

	typedef struct {
		logic [DATA_W-1:0]  read_data;
		logic [COUNT_W-1:0] pixels_set;
	} result_t;

	class frame_scoreboard;
		bit [7:0] frame [STORE_BYTES];
		result_t expected_words [$];
		int unsigned mismatches;
		int unsigned results_checked;
		int unsigned cmd_count [4];

		task report(string msg);
			if (mismatches < 100)
				$display("ERROR: %s", msg);
			mismatches++;
		endtask

		function int unsigned plot(int x, int y);
			int addr;
			if (x < 0 || y < 0 || x >= SCREEN_W || y >= SCREEN_H)
				return 0;
			addr = x + (y / PAGE_ROWS) * SCREEN_W;
			frame[addr] |= 8'(1 << (y % PAGE_ROWS));
			return 1;
		endfunction

		// bresenham stepping, every point clipped on its own
		function int unsigned trace_line(int ax, int ay, int bx, int by);
			int dx, dy, stepx, stepy, err, twice;
			int unsigned hits;
			dx = bx > ax ? bx - ax : ax - bx;
			dy = -(by > ay ? by - ay : ay - by);
			stepx = ax < bx ? 1 : -1;
			stepy = ay < by ? 1 : -1;
			err = dx + dy;
			hits = 0;
			for (int n = 0; n < LINE_POINT_MAX; n++) begin
				hits += plot(ax, ay);
				if (ax == bx && ay == by)
					break;
				twice = 2 * err;
				if (twice > dy) begin
					err += dy;
					ax += stepx;
				end
				if (twice < dx) begin
					err += dx;
					ay += stepy;
				end
			end
			return hits;
		endfunction

		function void note_command(action_t act, logic [7:0] sx, logic [7:0] sy,
				logic [7:0] ex, logic [7:0] ey, logic [9:0] idx);
			result_t res;
			res.read_data = '0;
			res.pixels_set = '0;
			cmd_count[act]++;
			case (act)
				ACT_CLEAR: begin
					foreach (frame[i])
						frame[i] = 8'h00;
				end
				ACT_PIXEL: res.pixels_set = COUNT_W'(plot(sx, sy));
				ACT_LINE:  res.pixels_set = COUNT_W'(trace_line(sx, sy, ex, ey));
				default: begin
					if (idx < STORE_BYTES)
						res.read_data = frame[idx];
				end
			endcase
			expected_words.push_back(res);
		endfunction

		task check_result(logic [23:0] word);
			result_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("result word %h with nothing expected", word));
				return;
			end
			want = expected_words.pop_front();
			results_checked++;
			if (word[7:0] !== want.read_data)
				report($sformatf("read_data %h, expected %h", word[7:0], want.read_data));
			if (word[16:8] !== want.pixels_set)
				report($sformatf("pixels_set %0d, expected %0d", word[16:8], want.pixels_set));
		endtask

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// start_x, start_y, end_x, end_y, byte_index, zero padding
	logic [47:0] s_tdata = '0;
	// action
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// read_data, pixels_set, zero padding
	logic [23:0] m_tdata;

	int src_idle_pct = 33;
	int sink_idle_pct = 62;
	int hot_x = 0;
	int hot_y = 0;

	frame_scoreboard sb = new();

	bresenham_line_framebuffer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// result side: check accepted words, then pick next ready
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic send_cmd(action_t act, logic [7:0] sx, logic [7:0] sy,
			logic [7:0] ex, logic [7:0] ey, logic [9:0] idx);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {6'b0, idx, ey, ex, sy, sx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_command(act, sx, sy, ex, ey, idx);
		if (act == ACT_PIXEL && sx < SCREEN_W && sy < SCREEN_H) begin
			hot_x = sx;
			hot_y = sy;
		end else if (act == ACT_LINE && ex < SCREEN_W && ey < SCREEN_H) begin
			hot_x = ex;
			hot_y = ey;
		end
	endtask

	task automatic send_random();
		int unsigned pick;
		logic [7:0] sx, sy, ex, ey;
		logic [9:0] idx;
		pick = $urandom_range(99);
		sx = 8'($urandom);
		sy = 8'($urandom);
		ex = 8'($urandom);
		ey = 8'($urandom);
		idx = 10'($urandom);
		if (pick < 3) begin
			send_cmd(ACT_CLEAR, sx, sy, ex, ey, idx);
		end else if (pick < 15) begin
			if ($urandom_range(4) != 0) begin
				sx = 8'($urandom_range(SCREEN_W - 1));
				sy = 8'($urandom_range(SCREEN_H - 1));
			end
			send_cmd(ACT_PIXEL, sx, sy, ex, ey, idx);
		end else if (pick < 60) begin
			// mostly on-screen lines, some reaching anywhere in the coordinate range
			if ($urandom_range(4) != 0) begin
				sx = 8'($urandom_range(SCREEN_W - 1));
				sy = 8'($urandom_range(SCREEN_H - 1));
				ex = 8'($urandom_range(SCREEN_W - 1));
				ey = 8'($urandom_range(SCREEN_H - 1));
			end
			send_cmd(ACT_LINE, sx, sy, ex, ey, idx);
		end else begin
			// half the reads land on a byte that was just drawn into
			if ($urandom_range(1) != 0)
				idx = 10'(hot_x + (hot_y / PAGE_ROWS) * SCREEN_W);
			send_cmd(ACT_READ, sx, sy, ex, ey, idx);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed commands: fresh store, corners, clipping, line shapes, clear
		send_cmd(ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   10'd0);
		send_cmd(ACT_READ,  8'd255, 8'd255, 8'd255, 8'd255, 10'd1023);
		send_cmd(ACT_PIXEL, 8'd0,   8'd0,   8'd255, 8'd255, 10'd1023);
		send_cmd(ACT_PIXEL, 8'd127, 8'd63,  8'd0,   8'd0,   10'd0);
		send_cmd(ACT_PIXEL, 8'd128, 8'd0,   8'd0,   8'd0,   10'd0);
		send_cmd(ACT_PIXEL, 8'd0,   8'd64,  8'd0,   8'd0,   10'd0);
		send_cmd(ACT_PIXEL, 8'd255, 8'd255, 8'd0,   8'd0,   10'd0);
		send_cmd(ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   10'd0);
		send_cmd(ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   10'd1023);
		send_cmd(ACT_LINE,  8'd5,   8'd5,   8'd5,   8'd5,   10'd0);
		send_cmd(ACT_LINE,  8'd0,   8'd0,   8'd127, 8'd0,   10'd0);
		send_cmd(ACT_LINE,  8'd10,  8'd0,   8'd10,  8'd63,  10'd0);
		send_cmd(ACT_LINE,  8'd0,   8'd63,  8'd127, 8'd0,   10'd0);
		send_cmd(ACT_LINE,  8'd200, 8'd10,  8'd10,  8'd50,  10'd0);
		send_cmd(ACT_LINE,  8'd255, 8'd255, 8'd0,   8'd0,   10'd0);
		send_cmd(ACT_LINE,  8'd0,   8'd0,   8'd255, 8'd3,   10'd0);
		send_cmd(ACT_LINE,  8'd120, 8'd60,  8'd135, 8'd70,  10'd0);
		send_cmd(ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   10'd10);
		send_cmd(ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   10'd5);
		send_cmd(ACT_CLEAR, 8'd77,  8'd33,  8'd200, 8'd150, 10'd555);
		send_cmd(ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   10'd10);
		send_cmd(ACT_LINE,  8'd127, 8'd63,  8'd0,   8'd255, 10'd0);
		send_cmd(ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   10'd1023);

		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			send_random();
		drain();

		src_idle_pct = 62;
		sink_idle_pct = 33;
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			send_random();
		drain();

		src_idle_pct = 0;
		sink_idle_pct = 0;
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			send_random();
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));

		$display("run covered %0d clear, %0d pixel, %0d line and %0d read commands",
			sb.cmd_count[ACT_CLEAR], sb.cmd_count[ACT_PIXEL],
			sb.cmd_count[ACT_LINE], sb.cmd_count[ACT_READ]);
		$display("%0d result words checked, %0d mismatches", sb.results_checked,
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_UNITS);
		$display("timeout with %0d results outstanding", sb.pending());
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/blfb_pkg.sv
rtl/blfb_ram.sv
rtl/blfb_line.sv
rtl/bresenham_line_framebuffer.sv
test/tb_top.sv
